// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL of the ordered key set table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define OKST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that must also hold while reset is asserted.
`define OKST_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/okst_pkg.sv =====
`default_nettype none

package okst_pkg;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_GET      = 2'd3
  } okst_op_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } okst_state_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } okst_cell_ctrl_t;

  localparam int unsigned KeyFieldW   = 32;
  localparam int unsigned RankFieldW  = 6;
  localparam int unsigned CountFieldW = 7;

endpackage

`default_nettype wire

// ===== rtl/okst_chan_if.sv =====
`default_nettype none

interface okst_cmd_if;
  logic                                  valid;
  logic                                  ready;
  okst_pkg::okst_op_e                    op;
  logic [okst_pkg::KeyFieldW-1:0]        key;
  logic [okst_pkg::RankFieldW-1:0]       rank;

  modport source (output valid, output op, output key, output rank, input ready);
  modport sink   (input valid, input op, input key, input rank, output ready);
endinterface

interface okst_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic                                  full_res;
  logic [okst_pkg::KeyFieldW-1:0]        found_key;
  logic [okst_pkg::CountFieldW-1:0]      count;

  modport source (output valid, output ok, output full_res, output found_key,
                  output count, input ready);
  modport sink   (input valid, input ok, input full_res, input found_key,
                  input count, output ready);
endinterface

`default_nettype wire

// ===== rtl/ordered_key_set_table.sv =====
// Ordered key set table: a sorted chain of cells, one key per cell, smallest key in cell 0.
// The cells compare at the input transfer; the result is written to the output register from the apply state.
// A new command is taken only in the idle state, after the compare step and the shift step of the
// cell chain; a result waiting on the output holds the apply step and so blocks the next input.
// Reset clears every cell's valid bit, the element count and the output valid at once.
`default_nettype none
`include "assert_macros.svh"

module ordered_key_set_table #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  okst_cmd_if.sink  cmd_i,
  okst_res_if.source res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > okst_pkg::RankFieldW) ? CntW : okst_pkg::RankFieldW;

  okst_pkg::okst_state_e state_q, state_d;
  okst_pkg::okst_op_e    op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [okst_pkg::RankFieldW-1:0] rank_q;
  logic [CntW-1:0]       count_q, count_d;

  logic                  out_valid_q, out_valid_d;
  logic                  ok_q, ok_d;
  logic                  full_q, full_d;
  logic [okst_pkg::KeyFieldW-1:0]   fkey_q, fkey_d;
  logic [okst_pkg::CountFieldW-1:0] cnt_out_q;

  logic                  accept, issue, hit, is_full, rank_ok;
  logic [KEY_BITS-1:0]   cell_key_in, sel_key;
  okst_pkg::okst_cell_ctrl_t ctrl;

  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid, cell_eq, cell_gt;

  // Cell chain.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] lkey, rkey;
    logic                lvalid, lgt, rvalid;

    if (i == 0) begin : g_first
      assign lkey   = '0;
      assign lvalid = 1'b1;
      assign lgt    = 1'b0;
    end else begin : g_left
      assign lkey   = cell_key[i-1];
      assign lvalid = cell_valid[i-1];
      assign lgt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rkey   = '0;
      assign rvalid = 1'b0;
    end else begin : g_right
      assign rkey   = cell_key[i+1];
      assign rvalid = cell_valid[i+1];
    end

    okst_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (cell_key_in),
      .left_key_i   (lkey),
      .left_valid_i (lvalid),
      .left_gt_i    (lgt),
      .right_key_i  (rkey),
      .right_valid_i(rvalid),
      .key_o        (cell_key[i]),
      .valid_o      (cell_valid[i]),
      .eq_o         (cell_eq[i]),
      .gt_o         (cell_gt[i])
    );
  end

  assign cmd_i.ready = (state_q == okst_pkg::ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign issue       = (state_q == okst_pkg::ST_APPLY) && (!out_valid_q || res_o.ready);

  // Cells compare against the incoming key at the transfer, then shift with the held key.
  assign cell_key_in = (state_q == okst_pkg::ST_IDLE) ? KEY_BITS'(cmd_i.key) : key_q;

  assign hit     = |cell_eq;
  assign is_full = (count_q == CntW'(CAPACITY));
  assign rank_ok = CmpW'(rank_q) < CmpW'(count_q);

  // The chain is sorted and packed, so the key of a given rank sits in that cell.
  always_comb begin
    sel_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CmpW'(i) == CmpW'(rank_q)) begin
        sel_key = sel_key | cell_key[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl        = '0;
    ctrl.cmp_en = accept;
    count_d     = count_q;
    ok_d        = 1'b0;
    full_d      = 1'b0;
    fkey_d      = '0;
    out_valid_d = (out_valid_q && !res_o.ready) ? 1'b1 : 1'b0;

    unique case (state_q)
      okst_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = okst_pkg::ST_APPLY;
        end
      end
      okst_pkg::ST_APPLY: begin
        unique case (op_q)
          okst_pkg::OP_INSERT: begin
            ok_d   = !hit && !is_full;
            full_d = !hit && is_full;
          end
          okst_pkg::OP_ERASE: begin
            ok_d = hit;
          end
          okst_pkg::OP_CONTAINS: begin
            ok_d = hit;
          end
          okst_pkg::OP_GET: begin
            ok_d   = rank_ok;
            fkey_d = rank_ok ? okst_pkg::KeyFieldW'(sel_key) : '0;
          end
          default: ;
        endcase
        if (issue) begin
          state_d     = okst_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          if (op_q == okst_pkg::OP_INSERT && ok_d) begin
            ctrl.ins_en = 1'b1;
            count_d     = count_q + CntW'(1);
          end
          if (op_q == okst_pkg::OP_ERASE && hit) begin
            ctrl.del_en = 1'b1;
            count_d     = count_q - CntW'(1);
          end
        end
      end
      default: state_d = okst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= okst_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= cmd_i.op;
      key_q  <= KEY_BITS'(cmd_i.key);
      rank_q <= cmd_i.rank;
    end
    if (issue) begin
      ok_q      <= ok_d;
      full_q    <= full_d;
      fkey_q    <= fkey_d;
      cnt_out_q <= okst_pkg::CountFieldW'(count_d);
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.ok        = ok_q;
  assign res_o.full_res  = full_q;
  assign res_o.found_key = fkey_q;
  assign res_o.count     = cnt_out_q;

  `OKST_ASSERT_NR(a_count_bound, clk_i, count_q <= CntW'(CAPACITY),
                  "element count above capacity")
  `OKST_ASSERT(a_count_matches_cells, clk_i, rst_ni, $countones(cell_valid) == count_q,
               "occupied cells differ from count")
  `OKST_ASSERT(a_ok_full_excl, clk_i, rst_ni, out_valid_q |-> !(ok_q && full_q),
               "result both ok and full")
  `OKST_ASSERT(a_key_needs_ok, clk_i, rst_ni, (out_valid_q && fkey_q != '0) |-> ok_q,
               "key returned on failed command")

  for (genvar i = 1; i < CAPACITY; i++) begin : g_order_chk
    `OKST_ASSERT(a_sorted, clk_i, rst_ni,
                 cell_valid[i] |-> (cell_valid[i-1] && cell_key[i-1] < cell_key[i]),
                 "cell chain not sorted")
  end

endmodule

`default_nettype wire

// ===== rtl/okst_cell.sv =====
`default_nettype none

module okst_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire okst_pkg::okst_cell_ctrl_t ctrl_i,
  input  wire logic [KEY_BITS-1:0]      key_i,
  input  wire logic [KEY_BITS-1:0]      left_key_i,
  input  wire logic                     left_valid_i,
  input  wire logic                     left_gt_i,
  input  wire logic [KEY_BITS-1:0]      right_key_i,
  input  wire logic                     right_valid_i,
  output logic [KEY_BITS-1:0]           key_o,
  output logic                          valid_o,
  output logic                          eq_o,
  output logic                          gt_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                valid_q, valid_d;
  logic                eq_q, eq_d;
  logic                gt_q, gt_d;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    eq_d    = eq_q;
    gt_d    = gt_q;
    if (ctrl_i.cmp_en) begin
      // An empty cell counts as greater, so the chain splits at one place.
      eq_d = valid_q && (key_q == key_i);
      gt_d = !valid_q || (key_q > key_i);
    end
    if (ctrl_i.ins_en) begin
      valid_d = valid_q | left_valid_i;
      if (gt_q) begin
        key_d = left_gt_i ? left_key_i : key_i;
      end
    end
    if (ctrl_i.del_en && (eq_q || gt_q)) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      eq_q    <= 1'b0;
      gt_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      eq_q    <= eq_d;
      gt_q    <= gt_d;
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign eq_o    = eq_q;
  assign gt_o    = gt_q;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic                             ok;
    logic                             full_res;
    logic [okst_pkg::KeyFieldW-1:0]   found_key;
    logic [okst_pkg::CountFieldW-1:0] count;
  } reply_t;

  // Tracks the key set in ascending order and the replies still owed by the block.
  class key_set_scoreboard;
    logic [okst_pkg::KeyFieldW-1:0] held_keys[$];
    reply_t               awaited_replies[$];
    int                   failures;
    int                   op_seen[4];
    int                   ok_replies;
    int                   full_refusals;
    int                   dup_inserts;
    int                   peak_size;

    function new();
      failures      = 0;
      ok_replies    = 0;
      full_refusals = 0;
      dup_inserts   = 0;
      peak_size     = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function int size();
      return held_keys.size();
    endfunction

    function int locate(logic [okst_pkg::KeyFieldW-1:0] k);
      foreach (held_keys[i]) if (held_keys[i] == k) return i;
      return -1;
    endfunction

    function void note_command(okst_pkg::okst_op_e op, logic [okst_pkg::KeyFieldW-1:0] k,
                               logic [okst_pkg::RankFieldW-1:0] r);
      reply_t want;
      int     idx;
      int     pos;
      want      = '0;
      idx       = locate(k);
      op_seen[op]++;
      case (op)
        okst_pkg::OP_INSERT: begin
          // A duplicate is refused before the capacity is looked at.
          if (idx >= 0) begin
            dup_inserts++;
          end else if (held_keys.size() >= TableDepth) begin
            want.full_res = 1'b1;
            full_refusals++;
          end else begin
            pos = 0;
            while (pos < held_keys.size() && held_keys[pos] < k) pos++;
            held_keys.insert(pos, k);
            want.ok = 1'b1;
          end
        end
        okst_pkg::OP_ERASE: begin
          if (idx >= 0) begin
            held_keys.delete(idx);
            want.ok = 1'b1;
          end
        end
        okst_pkg::OP_CONTAINS: begin
          want.ok = (idx >= 0);
        end
        okst_pkg::OP_GET: begin
          if (int'(r) < held_keys.size()) begin
            want.found_key = held_keys[r];
            want.ok        = 1'b1;
          end
        end
      endcase
      want.count = okst_pkg::CountFieldW'(held_keys.size());
      if (want.ok) ok_replies++;
      if (held_keys.size() > peak_size) peak_size = held_keys.size();
      awaited_replies.push_back(want);
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        $error("result with no command outstanding: ok=%0b full_res=%0b key=%h count=%0d",
               got.ok, got.full_res, got.found_key, got.count);
        failures++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0b, got %0b", want.ok, got.ok);
        failures++;
      end
      if (got.full_res !== want.full_res) begin
        $error("full_res: expected %0b, got %0b", want.full_res, got.full_res);
        failures++;
      end
      if (got.found_key !== want.found_key) begin
        $error("found_key: expected %h, got %h", want.found_key, got.found_key);
        failures++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   stall_request;
  int   hold_left;

  key_set_scoreboard sb;

  okst_cmd_if cmd_if ();
  okst_res_if res_if ();

  ordered_key_set_table #(
    .CAPACITY(TableDepth),
    .KEY_BITS(okst_pkg::KeyFieldW)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Keys are held ones with the given percentage (to hit), else some extremes and small values,
  // and otherwise fully random values that are almost always new.
  function automatic logic [okst_pkg::KeyFieldW-1:0] pick_key(int hit_pct);
    int sel;
    if (sb.size() > 0 && roll(hit_pct)) return sb.held_keys[$urandom_range(0, sb.size() - 1)];
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return okst_pkg::KeyFieldW'($urandom_range(0, 15));
    return $urandom;
  endfunction

  function automatic logic [okst_pkg::RankFieldW-1:0] pick_rank();
    int sel;
    sel = $urandom_range(0, 99);
    if (sb.size() > 0 && sel < 75) begin
      return okst_pkg::RankFieldW'($urandom_range(0, sb.size() - 1));
    end
    if (sel < 85 && sb.size() < (1 << okst_pkg::RankFieldW)) begin
      return okst_pkg::RankFieldW'(sb.size());
    end
    return okst_pkg::RankFieldW'($urandom_range(0, (1 << okst_pkg::RankFieldW) - 1));
  endfunction

  // Offers one command and returns once its transfer has happened.
  task automatic send_cmd(okst_pkg::okst_op_e op, logic [okst_pkg::KeyFieldW-1:0] k,
                          logic [okst_pkg::RankFieldW-1:0] r);
    while (roll(tx_idle_pct)) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.op    <= op;
    cmd_if.key   <= k;
    cmd_if.rank  <= r;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_command(op, k, r);
  endtask

  task automatic run_random(int n, int ins_w, int era_w, int con_w);
    int                 w;
    okst_pkg::okst_op_e op;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < ins_w) op = okst_pkg::OP_INSERT;
      else if (w < ins_w + era_w) op = okst_pkg::OP_ERASE;
      else if (w < ins_w + era_w + con_w) op = okst_pkg::OP_CONTAINS;
      else op = okst_pkg::OP_GET;
      case (op)
        okst_pkg::OP_INSERT:   send_cmd(op, pick_key(20), okst_pkg::RankFieldW'($urandom));
        okst_pkg::OP_ERASE:    send_cmd(op, pick_key(70), okst_pkg::RankFieldW'($urandom));
        okst_pkg::OP_CONTAINS: send_cmd(op, pick_key(50), okst_pkg::RankFieldW'($urandom));
        default:               send_cmd(op, $urandom, pick_rank());
      endcase
    end
  endtask

  // Receiver: checks every result transfer and drives ready.
  initial begin
    res_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready)
        sb.check_result('{res_if.ok, res_if.full_res, res_if.found_key, res_if.count});
      if (stall_request > 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !roll(rx_stall_pct);
      end
    end
  end

  initial begin
    sb            = new();
    cycle_count   = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    stall_request = 0;
    rst_n         <= 1'b0;
    cmd_if.valid  <= 1'b0;
    cmd_if.op     <= okst_pkg::OP_INSERT;
    cmd_if.key    <= '0;
    cmd_if.rank   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, duplicates, misses and out-of-range ranks.
    send_cmd(okst_pkg::OP_GET,      '1,            '0);
    send_cmd(okst_pkg::OP_CONTAINS, '0,            '1);
    send_cmd(okst_pkg::OP_ERASE,    '0,            '0);
    send_cmd(okst_pkg::OP_INSERT,   '0,            '1);
    send_cmd(okst_pkg::OP_INSERT,   '1,            '0);
    send_cmd(okst_pkg::OP_INSERT,   '0,            '0);
    send_cmd(okst_pkg::OP_INSERT,   32'h8000_0000, '0);
    send_cmd(okst_pkg::OP_INSERT,   32'h0000_0001, '0);
    send_cmd(okst_pkg::OP_INSERT,   '1,            '1);
    send_cmd(okst_pkg::OP_CONTAINS, '1,            '0);
    send_cmd(okst_pkg::OP_CONTAINS, 32'h7fff_ffff, '0);
    send_cmd(okst_pkg::OP_GET,      '0,            6'd0);
    send_cmd(okst_pkg::OP_GET,      '1,            6'd3);
    send_cmd(okst_pkg::OP_GET,      '0,            6'd4);
    send_cmd(okst_pkg::OP_GET,      '0,            '1);
    send_cmd(okst_pkg::OP_ERASE,    '1,            '1);
    send_cmd(okst_pkg::OP_ERASE,    '1,            '0);
    send_cmd(okst_pkg::OP_CONTAINS, '1,            '0);
    send_cmd(okst_pkg::OP_INSERT,   32'h7fff_ffff, '0);
    send_cmd(okst_pkg::OP_GET,      '0,            6'd2);
    send_cmd(okst_pkg::OP_ERASE,    '0,            '0);
    send_cmd(okst_pkg::OP_GET,      '0,            6'd0);

    // Random phases; the insert-heavy one drives the table to capacity.
    run_random(110, 55, 15, 15);
    tx_idle_pct = 56;
    run_random(110, 75, 5, 10);
    tx_idle_pct  = 0;
    rx_stall_pct = 56;
    run_random(110, 25, 25, 25);
    tx_idle_pct  = 15;
    rx_stall_pct = 15;
    run_random(110, 15, 50, 15);
    // Long receiver hold-off while commands keep coming, so the input backs up.
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    stall_request = 300;
    run_random(110, 40, 20, 20);

    cmd_if.valid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.awaited_replies.size() != 0) begin
      $error("%0d results never arrived", sb.awaited_replies.size());
      sb.failures++;
    end

    $display("Ran %0d inserts, %0d erases, %0d lookups, %0d rank reads; %0d succeeded.",
             sb.op_seen[okst_pkg::OP_INSERT], sb.op_seen[okst_pkg::OP_ERASE],
             sb.op_seen[okst_pkg::OP_CONTAINS], sb.op_seen[okst_pkg::OP_GET],
             sb.ok_replies);
    $display("Peak size %0d of %0d, %0d refused as full, %0d duplicate inserts.",
             sb.peak_size, TableDepth, sb.full_refusals, sb.dup_inserts);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
